### design/blw_pkg.sv
// Shared types and constants for the one-dimensional blend weight block.
package blw_pkg;

    localparam int KEY_W   = 16;
    localparam int CNT_W   = 5;
    localparam int IDX_W   = 4;
    localparam int WGT_W   = 16;

    localparam logic [WGT_W-1:0] ONE_Q15 = 16'h8000;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic [IDX_W-1:0]        key_index;
        logic signed [KEY_W-1:0] key_value;
        logic signed [KEY_W-1:0] query_value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] entry_index;
        logic [WGT_W-1:0] weight;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] num;
        logic [KEY_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [WGT_W-1:0] quot;
    } div_rsp_t;

endpackage

### design/blend_weights_1d_top.sv
// Blend weight engine: binary search, fraction divide and per-entry weight emission.
// A query with n breakpoints runs the binary search (table read then compare per probe, one
// more read when the range empties), the neighbor reads and mix setup, the divider when a
// fraction is needed, a step to prime the table read, then one weight beat per cycle while
// m_ready holds.
// Synchronous active-low reset clears the sequencer, output valid and key_count.
module blend_weights_1d_top #(
    parameter int MAX_KEYS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [4:0]            cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  blw_pkg::in_item_t     s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output blw_pkg::out_item_t    m_item
);

    localparam int DEPTH = (MAX_KEYS < 16) ? MAX_KEYS : 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_NB_TO,
        ST_NB_FROM,
        ST_NB_CAP,
        ST_MIX,
        ST_DIV,
        ST_EMIT_PRE,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [4:0]             key_count_reg;
    logic [CW-1:0]          n_reg, n_next;
    logic signed [15:0]     v_reg, v_next;
    logic [CW-1:0]          start_reg, start_next;
    logic [CW-1:0]          endp_reg, endp_next;
    logic [CW-1:0]          mid_reg, mid_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          k_reg, k_next;
    logic signed [15:0]     to_reg, to_next;
    logic signed [15:0]     from_reg, from_next;
    logic                   has_to_reg, has_to_next;
    logic                   has_from_reg, has_from_next;
    logic [15:0]            mix_reg, mix_next;
    logic [15:0]            mixf_reg, mixf_next;
    logic                   m_valid_reg, m_valid_next;
    blw_pkg::out_item_t     m_item_reg, m_item_next;

    logic [AW-1:0]          rd_addr;
    logic [15:0]            rd_data;
    logic signed [15:0]     kv;
    logic                   mem_we;
    logic                   slot_ok;
    logic [CW-1:0]          n_calc;
    logic [CW:0]            mid_sum;
    logic [CW-1:0]          mid_c;
    logic [CW-1:0]          idx_m1;
    logic [CW-1:0]          k_plus1;
    logic signed [16:0]     num_s;
    logic signed [16:0]     den_s;
    logic [16:0]            num_abs;
    logic [16:0]            den_abs;
    logic                   is_last;
    logic [15:0]            w;
    blw_pkg::div_req_t      div_req;
    blw_pkg::div_rsp_t      div_rsp;

    blw_key_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_key_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (s_item.key_index[AW-1:0]),
        .wr_data (s_item.key_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    blw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign kv      = $signed(rd_data);
    assign slot_ok = ({28'd0, s_item.key_index} < 32'(DEPTH));
    assign n_calc  = (32'(key_count_reg) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(key_count_reg);
    assign mid_sum = {1'b0, start_reg} + {1'b0, endp_reg} - {{CW{1'b0}}, 1'b1};
    assign mid_c   = mid_sum[CW:1];
    assign idx_m1  = idx_reg - {{(CW-1){1'b0}}, 1'b1};
    assign k_plus1 = k_reg + {{(CW-1){1'b0}}, 1'b1};
    assign num_s   = {v_reg[15], v_reg} - {from_reg[15], from_reg};
    assign den_s   = {to_reg[15], to_reg} - {from_reg[15], from_reg};
    assign num_abs = num_s[16] ? (~num_s + 17'd1) : num_s;
    assign den_abs = den_s[16] ? (~den_s + 17'd1) : den_s;
    assign is_last = (k_reg == (n_reg - {{(CW-1){1'b0}}, 1'b1}));

    always_comb begin
        if (has_to_reg && kv == to_reg) begin
            w = mix_reg;
        end else if (has_from_reg && kv == from_reg) begin
            w = mixf_reg;
        end else begin
            w = '0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        v_next        = v_reg;
        start_next    = start_reg;
        endp_next     = endp_reg;
        mid_next      = mid_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        to_next       = to_reg;
        from_next     = from_reg;
        has_to_next   = has_to_reg;
        has_from_next = has_from_reg;
        mix_next      = mix_reg;
        mixf_next     = mixf_reg;
        m_item_next   = m_item_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        rd_addr       = k_reg[AW-1:0];
        mem_we        = 1'b0;
        div_req       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_item.opcode == blw_pkg::OP_LOAD) begin
                        mem_we = slot_ok;
                    end else if (n_calc != '0) begin
                        n_next     = n_calc;
                        v_next     = s_item.query_value;
                        start_next = '0;
                        endp_next  = n_calc;
                        idx_next   = '0;
                        k_next     = '0;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                rd_addr  = mid_c[AW-1:0];
                mid_next = mid_c;
                state_next = (start_reg < endp_reg) ? ST_CMP : ST_NB_TO;
            end
            ST_CMP: begin
                if (kv < v_reg) begin
                    start_next = mid_reg + {{(CW-1){1'b0}}, 1'b1};
                    idx_next   = mid_reg + {{(CW-1){1'b0}}, 1'b1};
                    state_next = ST_PROBE;
                end else if (kv > v_reg) begin
                    endp_next  = mid_reg;
                    idx_next   = start_reg;
                    state_next = ST_PROBE;
                end else begin
                    idx_next   = mid_reg;
                    state_next = ST_NB_TO;
                end
            end
            ST_NB_TO: begin
                rd_addr       = idx_reg[AW-1:0];
                has_to_next   = (idx_reg < n_reg);
                has_from_next = (idx_reg != '0);
                state_next    = ST_NB_FROM;
            end
            ST_NB_FROM: begin
                rd_addr    = idx_m1[AW-1:0];
                to_next    = kv;
                state_next = ST_NB_CAP;
            end
            ST_NB_CAP: begin
                from_next  = kv;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                if (!has_to_reg || !has_from_reg || to_reg == from_reg) begin
                    mix_next   = blw_pkg::ONE_Q15;
                    mixf_next  = blw_pkg::ONE_Q15;
                    state_next = ST_EMIT_PRE;
                end else if (num_s[16] != den_s[16]) begin
                    // Opposite signs only arise from an unsorted table: clip to zero.
                    mix_next   = '0;
                    mixf_next  = blw_pkg::ONE_Q15;
                    state_next = ST_EMIT_PRE;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = num_abs[15:0];
                    div_req.den   = den_abs[15:0];
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    mix_next   = div_rsp.quot;
                    mixf_next  = blw_pkg::ONE_Q15 - div_rsp.quot;
                    state_next = ST_EMIT_PRE;
                end
            end
            ST_EMIT_PRE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_item_next.entry_index = blw_pkg::IDX_W'(k_reg);
                    m_item_next.weight      = w;
                    m_item_next.last        = is_last;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next  = k_plus1;
                        rd_addr = k_plus1[AW-1:0];
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            key_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                key_count_reg <= cfg_wr_data;
            end
        end
        n_reg        <= n_next;
        v_reg        <= v_next;
        start_reg    <= start_next;
        endp_reg     <= endp_next;
        mid_reg      <= mid_next;
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        to_reg       <= to_next;
        from_reg     <= from_next;
        has_to_reg   <= has_to_next;
        has_from_reg <= has_from_next;
        mix_reg      <= mix_next;
        mixf_reg     <= mixf_next;
        m_item_reg   <= m_item_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### design/blw_key_mem.sv
// Breakpoint table: one write port, one registered read port.
module blw_key_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [blw_pkg::KEY_W-1:0]    wr_data,
    input  logic [AW-1:0]                rd_addr,
    output logic [blw_pkg::KEY_W-1:0]    rd_data
);

    logic [blw_pkg::KEY_W-1:0] mem [DEPTH];
    logic [blw_pkg::KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/blw_div.sv
// Radix-2 restoring divider for the Q1.15 blend fraction, saturating at one.
module blw_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  blw_pkg::div_req_t   req,
    output blw_pkg::div_rsp_t   rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [15:0] bits_reg;
    logic [15:0] den_reg;
    logic [15:0] quot_reg;

    logic [16:0] trial;
    logic [16:0] diff;
    logic        fit;
    logic [15:0] q_step;

    assign trial  = {rem_reg, bits_reg[15]};
    assign diff   = trial - {1'b0, den_reg};
    assign fit    = (trial >= {1'b0, den_reg});
    assign q_step = {quot_reg[14:0], fit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                den_reg <= req.den;
                // Quotient of two or more always clips, so skip the loop.
                if ({1'b0, req.num} >= {req.den, 1'b0}) begin
                    quot_reg <= blw_pkg::ONE_Q15;
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end else begin
                    rem_reg  <= {1'b0, req.num[15:1]};
                    bits_reg <= {req.num[0], 15'd0};
                    quot_reg <= '0;
                    cnt_reg  <= 4'd15;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg  <= fit ? diff[15:0] : trial[15:0];
                bits_reg <= {bits_reg[14:0], 1'b0};
                if (cnt_reg == 4'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quot_reg <= (q_step > blw_pkg::ONE_Q15) ? blw_pkg::ONE_Q15 : q_step;
                end else begin
                    quot_reg <= q_step;
                    cnt_reg  <= cnt_reg - 4'd1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule
